### rtl/sss_pkg.sv
// Shared types, widths and codes for the stutter step sequencer.
package sss_pkg;

    // Number of trigger outputs actually built (1 to 4)
    localparam int NUM_OUTPUTS  = 4;
    localparam int SEL_W        = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;

    // Configuration port
    localparam int PATTERN_CNT  = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // Item field widths
    localparam int ACTION_W     = 2;
    localparam int TIME_W       = 32;
    localparam int RAND_OUT_W   = 2;
    localparam int BIT_IDX_W    = 4;
    localparam int TRIG_W       = 4;
    localparam int STEPS        = 16;
    localparam int LOOP_POS_W   = 3;
    localparam int LOOP_LEN_W   = 4;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PRESS = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    // Loop lengths
    localparam logic [LOOP_LEN_W-1:0] LOOP_LEN_2 = 4'd2;
    localparam logic [LOOP_LEN_W-1:0] LOOP_LEN_4 = 4'd4;
    localparam logic [LOOP_LEN_W-1:0] LOOP_LEN_8 = 4'd8;

    // Floor on the step interval in ms
    localparam logic [TIME_W-1:0] MIN_STEP_MS = 32'd5;

    typedef logic [STEPS-1:0] t_pattern;

endpackage

### rtl/sss_in_if.sv
// Input item channel: action, time, tempo, sync and random picks.
interface sss_in_if import sss_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [TIME_W-1:0]     now_ms;
    logic [TIME_W-1:0]     tempo_interval_ms;
    logic                  resync;
    logic [RAND_OUT_W-1:0] rand_output;
    logic [BIT_IDX_W-1:0]  rand_bit_a;
    logic [BIT_IDX_W-1:0]  rand_bit_b;

    modport source (
        output valid, action, now_ms, tempo_interval_ms, resync,
               rand_output, rand_bit_a, rand_bit_b,
        input  ready
    );
    modport sink (
        input  valid, action, now_ms, tempo_interval_ms, resync,
               rand_output, rand_bit_a, rand_bit_b,
        output ready
    );
endinterface

### rtl/sss_out_if.sv
// Result item channel: trigger mask, step bit and stutter flag.
interface sss_out_if import sss_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [TRIG_W-1:0]    trigger_mask;
    logic [BIT_IDX_W-1:0] step_bit_used;
    logic                 stutter_on;

    modport source (
        output valid, trigger_mask, step_bit_used, stutter_on,
        input  ready
    );
    modport sink (
        input  valid, trigger_mask, step_bit_used, stutter_on,
        output ready
    );
endinterface

### rtl/stutter_step_sequencer_core.sv
// Stutter step sequencer: step scheduling, stutter loop and trigger generation.
//
//   channel   dir   handshake          payload
//   i_in      in    valid/ready        action, now_ms, tempo_interval_ms, resync,
//                                      rand_output, rand_bit_a, rand_bit_b
//   o_out     out   valid/ready        trigger_mask, step_bit_used, stutter_on
//   i_cfg_*   in    write enable only  i_cfg_idx selects pattern_out0..3, i_cfg_data
//
// One item per clock while i_in.ready is high. Each item updates the sequencer
// state and, for a due step, the result register in the cycle it is accepted.
// The result register is the only stage: i_in.ready is high while it is empty
// or being drained, so a stalled result blocks input only while o_out.ready is low.
// Synchronous active-low reset clears patterns, masks, schedule and loop state.
module stutter_step_sequencer_core import sss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sss_in_if.sink                i_in,
    sss_out_if.source             o_out
);

    // Reduce the random output pick modulo NUM_OUTPUTS
    function automatic logic [SEL_W-1:0] nudge_sel(input logic [RAND_OUT_W-1:0] r);
        logic [RAND_OUT_W:0] v;
        v = {1'b0, r};
        for (int k = 0; k < 4; k++) begin
            if (v >= (RAND_OUT_W+1)'(NUM_OUTPUTS)) begin
                v = v - (RAND_OUT_W+1)'(NUM_OUTPUTS);
            end
        end
        return v[SEL_W-1:0];
    endfunction

    // State
    t_pattern                r_pattern [PATTERN_CNT];
    t_pattern                r_masks   [NUM_OUTPUTS];
    t_pattern                n_masks   [NUM_OUTPUTS];
    logic                    r_stutter_en, n_stutter_en;
    logic [LOOP_LEN_W-1:0]   r_loop_len, n_loop_len;
    logic [LOOP_POS_W-1:0]   r_loop_pos, n_loop_pos;
    logic [BIT_IDX_W-1:0]    r_main_step, n_main_step;
    logic [TIME_W-1:0]       r_next_due, n_next_due;

    // Result register
    logic                    r_out_valid, n_out_valid;
    logic [TRIG_W-1:0]       r_trig, n_trig;
    logic [BIT_IDX_W-1:0]    r_step_bit, n_step_bit;
    logic                    r_stut, n_stut;

    // Step datapath
    logic                    in_acc;
    logic [TIME_W-1:0]       step_iv;
    logic [TIME_W-1:0]       due_base;
    logic [TIME_W-1:0]       due_sum;
    logic [TIME_W-1:0]       now_sum;
    logic [TIME_W-1:0]       due_next;
    logic                    step_due;
    logic [LOOP_POS_W-1:0]   lp_sync;
    logic [BIT_IDX_W-1:0]    ms_sync;
    logic [BIT_IDX_W-1:0]    pos;
    logic [TRIG_W-1:0]       trig;
    logic [LOOP_LEN_W-1:0]   lp_inc;
    logic                    loop_wrap;
    logic [SEL_W-1:0]        nudge_idx;
    t_pattern                toggle;

    assign i_in.ready   = !r_out_valid || o_out.ready;
    assign in_acc       = i_in.valid && i_in.ready;

    // Step interval: quarter of the beat with a floor
    assign step_iv = ({2'b00, i_in.tempo_interval_ms[TIME_W-1:2]} < MIN_STEP_MS)
                   ? MIN_STEP_MS : {2'b00, i_in.tempo_interval_ms[TIME_W-1:2]};

    // Schedule: unscheduled takes now, advance by interval, catch up if behind
    assign due_base = (r_next_due == '0) ? i_in.now_ms : r_next_due;
    assign step_due = !(i_in.now_ms < due_base);
    assign due_sum  = due_base + step_iv;
    assign now_sum  = i_in.now_ms + step_iv;
    assign due_next = (due_sum < i_in.now_ms) ? now_sum : due_sum;

    // Position after an optional sync
    assign lp_sync = i_in.resync ? '0 : r_loop_pos;
    assign ms_sync = i_in.resync ? '0 : r_main_step;
    assign pos     = r_stutter_en ? {1'b0, lp_sync} : ms_sync;

    // Trigger bits from pattern XOR variation mask
    always_comb begin
        trig = '0;
        for (int i = 0; i < NUM_OUTPUTS; i++) begin
            trig[i] = r_pattern[i][pos] ^ r_masks[i][pos];
        end
    end

    // Loop advance and mask nudge
    assign lp_inc    = {1'b0, lp_sync} + LOOP_LEN_W'(1);
    assign loop_wrap = (lp_inc >= r_loop_len);
    assign nudge_idx = nudge_sel(i_in.rand_output);
    assign toggle    = (t_pattern'(1) << i_in.rand_bit_a) | (t_pattern'(1) << i_in.rand_bit_b);

    // Next state for one accepted item
    always_comb begin
        n_stutter_en = r_stutter_en;
        n_loop_len   = r_loop_len;
        n_loop_pos   = r_loop_pos;
        n_main_step  = r_main_step;
        n_next_due   = r_next_due;
        n_masks      = r_masks;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_trig       = r_trig;
        n_step_bit   = r_step_bit;
        n_stut       = r_stut;
        if (in_acc) begin
            case (i_in.action)
                ACT_PRESS: begin
                    if (!r_stutter_en) begin
                        n_stutter_en = 1'b1;
                        n_loop_len   = LOOP_LEN_2;
                    end else if (r_loop_len == LOOP_LEN_2) begin
                        n_loop_len = LOOP_LEN_4;
                    end else if (r_loop_len == LOOP_LEN_4) begin
                        n_loop_len = LOOP_LEN_8;
                    end else begin
                        n_loop_len = LOOP_LEN_2;
                    end
                end
                ACT_CLEAR: begin
                    n_stutter_en = 1'b0;
                    n_loop_len   = LOOP_LEN_2;
                    n_loop_pos   = '0;
                    n_main_step  = '0;
                    n_next_due   = '0;
                    for (int i = 0; i < NUM_OUTPUTS; i++) begin
                        n_masks[i] = '0;
                    end
                end
                ACT_TICK: begin
                    n_loop_pos  = lp_sync;
                    n_main_step = ms_sync;
                    n_next_due  = due_base;
                    if (step_due) begin
                        n_next_due  = due_next;
                        n_out_valid = 1'b1;
                        n_trig      = trig;
                        n_step_bit  = pos;
                        n_stut      = r_stutter_en;
                        if (r_stutter_en) begin
                            if (loop_wrap) begin
                                n_loop_pos = '0;
                                n_masks[nudge_idx] = r_masks[nudge_idx] ^ toggle;
                            end else begin
                                n_loop_pos = lp_inc[LOOP_POS_W-1:0];
                            end
                        end else begin
                            n_main_step = ms_sync + BIT_IDX_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hold state and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stutter_en <= 1'b0;
            r_loop_len   <= LOOP_LEN_2;
            r_loop_pos   <= '0;
            r_main_step  <= '0;
            r_next_due   <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NUM_OUTPUTS; i++) begin
                r_masks[i] <= '0;
            end
            for (int i = 0; i < PATTERN_CNT; i++) begin
                r_pattern[i] <= '0;
            end
        end else begin
            r_stutter_en <= n_stutter_en;
            r_loop_len   <= n_loop_len;
            r_loop_pos   <= n_loop_pos;
            r_main_step  <= n_main_step;
            r_next_due   <= n_next_due;
            r_out_valid  <= n_out_valid;
            r_masks      <= n_masks;
            if (i_cfg_we) begin
                r_pattern[i_cfg_idx] <= i_cfg_data;
            end
        end
        r_trig     <= n_trig;
        r_step_bit <= n_step_bit;
        r_stut     <= n_stut;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.trigger_mask  = r_trig;
    assign o_out.step_bit_used = r_step_bit;
    assign o_out.stutter_on    = r_stut;

    // Loop length stays one of the three legal lengths
    a_loop_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loop_len == LOOP_LEN_2 || r_loop_len == LOOP_LEN_4 || r_loop_len == LOOP_LEN_8)
        else $error("loop length out of set");

    // A stutter step never uses a bit beyond the longest loop
    a_stut_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.stutter_on) |-> !o_out.step_bit_used[BIT_IDX_W-1])
        else $error("stutter step bit beyond loop");

    // A button press always leaves the stutter loop enabled
    a_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.action == ACT_PRESS) |=> r_stutter_en)
        else $error("press did not enable stutter");

    // A full reset clears the sequencer position and schedule
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.action == ACT_CLEAR) |=>
        (!r_stutter_en && r_main_step == '0 && r_loop_pos == '0 && r_next_due == '0))
        else $error("full reset left state behind");

endmodule

### tb/stutter_step_sequencer_core_tb.sv
// Testbench for the stutter step sequencer core: directed and random items, predicted steps.
`timescale 1ns / 100ps

module stutter_step_sequencer_core_tb;
    import sss_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 3;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 150;

    // Action code the block leaves alone
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [TIME_W-1:0]     now_ms;
        logic [TIME_W-1:0]     tempo_interval_ms;
        logic                  resync;
        logic [RAND_OUT_W-1:0] rand_output;
        logic [BIT_IDX_W-1:0]  rand_bit_a;
        logic [BIT_IDX_W-1:0]  rand_bit_b;
        logic                  drain_first;
    } seq_input_t;

    typedef struct packed {
        logic [TRIG_W-1:0]    trigger_mask;
        logic [BIT_IDX_W-1:0] step_bit_used;
        logic                 stutter_on;
    } step_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sss_in_if  in_ch ();
    sss_out_if res_ch ();

    stutter_step_sequencer_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (res_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Predicted sequencer state
    t_pattern              pattern_model [PATTERN_CNT];
    t_pattern              nudge_mask [PATTERN_CNT];
    logic                  stutter_mode;
    logic [LOOP_LEN_W-1:0] loop_len;
    logic [LOOP_POS_W-1:0] loop_pos;
    logic [BIT_IDX_W-1:0]  main_step;
    logic [TIME_W-1:0]     due_ms;

    seq_input_t   sequencer_inputs [$];
    step_result_t expected_steps [$];

    // Random stream state
    logic [TIME_W-1:0] gen_ms    = 32'd1000;
    logic [TIME_W-1:0] gen_tempo = 32'd200;

    bit in_taken;
    int send_gap, send_quiet, hold_cycles, recv_quiet, stuck_cycles;
    int mismatches, results_checked, stutter_results, loop_wraps;
    int ticks, ticks_due, presses, clears, ignored;

    function automatic void clear_sequencer();
        stutter_mode = 1'b0;
        loop_len     = LOOP_LEN_2;
        loop_pos     = '0;
        main_step    = '0;
        due_ms       = '0;
        foreach (nudge_mask[i]) nudge_mask[i] = '0;
    endfunction

    // Apply one item to the predicted state; return 1 when a step is due
    function automatic bit advance_sequencer(input seq_input_t it, output step_result_t res);
        logic [TIME_W-1:0]    step_ms;
        logic [BIT_IDX_W-1:0] pos;
        int                   next_loop;
        int                   sel;
        res = '0;
        case (it.action)
            ACT_PRESS: begin
                if (!stutter_mode) begin
                    stutter_mode = 1'b1;
                    loop_len     = LOOP_LEN_2;
                end else if (loop_len == LOOP_LEN_2) begin
                    loop_len = LOOP_LEN_4;
                end else if (loop_len == LOOP_LEN_4) begin
                    loop_len = LOOP_LEN_8;
                end else begin
                    loop_len = LOOP_LEN_2;
                end
                return 1'b0;
            end
            ACT_CLEAR: begin
                clear_sequencer();
                return 1'b0;
            end
            ACT_TICK: begin
            end
            default: return 1'b0;
        endcase

        if (it.resync) begin
            main_step = '0;
            loop_pos  = '0;
        end
        step_ms = it.tempo_interval_ms >> 2;
        if (step_ms < MIN_STEP_MS) step_ms = MIN_STEP_MS;
        if (due_ms == '0) due_ms = it.now_ms;
        if (it.now_ms < due_ms) return 1'b0;

        // Reschedule, catching up when the sum falls behind now
        due_ms = due_ms + step_ms;
        if (due_ms < it.now_ms) due_ms = it.now_ms + step_ms;

        pos = stutter_mode ? BIT_IDX_W'(loop_pos) : main_step;
        for (int i = 0; i < NUM_OUTPUTS; i++)
            res.trigger_mask[i] = pattern_model[i][pos] ^ nudge_mask[i][pos];
        res.step_bit_used = pos;
        res.stutter_on    = stutter_mode;

        // Advance the loop; a completed loop nudges one output's mask
        if (stutter_mode) begin
            next_loop = int'(loop_pos) + 1;
            if (next_loop >= int'(loop_len)) begin
                loop_pos = '0;
                sel = int'(it.rand_output) % NUM_OUTPUTS;
                nudge_mask[sel] ^= (t_pattern'(1) << it.rand_bit_a) |
                                   (t_pattern'(1) << it.rand_bit_b);
                loop_wraps++;
            end else begin
                loop_pos = LOOP_POS_W'(next_loop);
            end
        end else begin
            main_step = main_step + 1'b1;
        end
        return 1'b1;
    endfunction

    // Idle length: mostly none, some short, a few long, with quiet stretches
    function automatic int pick_idle(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_item(input logic [ACTION_W-1:0] act, input logic [TIME_W-1:0] now,
                              input logic [TIME_W-1:0] tempo, input logic sync,
                              input logic [RAND_OUT_W-1:0] pick,
                              input logic [BIT_IDX_W-1:0] bit_a,
                              input logic [BIT_IDX_W-1:0] bit_b);
        seq_input_t it;
        it.action            = act;
        it.now_ms            = now;
        it.tempo_interval_ms = tempo;
        it.resync            = sync;
        it.rand_output       = pick;
        it.rand_bit_a        = bit_a;
        it.rand_bit_b        = bit_b;
        it.drain_first       = 1'b0;
        sequencer_inputs.push_back(it);
    endtask

    // Mostly ticks paced near the step interval, with presses, clears and noise
    task automatic queue_random_phase(input int count);
        seq_input_t        it;
        logic [TIME_W-1:0] step_ms;
        int                made;
        int                r;
        made = 0;
        while (made < count) begin
            it             = '0;
            it.rand_output = RAND_OUT_W'($urandom_range(0, 3));
            it.rand_bit_a  = BIT_IDX_W'($urandom_range(0, 15));
            it.rand_bit_b  = BIT_IDX_W'($urandom_range(0, 15));
            it.drain_first = (made == count / 2);
            r = $urandom_range(0, 99);
            if (r < 6) begin
                it.action = ACT_PRESS;
            end else if (r < 8) begin
                it.action = ACT_CLEAR;
            end else if (r < 10) begin
                it.action = ACT_UNUSED;
            end else begin
                it.action = ACT_TICK;
                if ($urandom_range(0, 99) < 6) begin
                    r = $urandom_range(0, 99);
                    if (r < 70) gen_tempo = $urandom_range(20, 400);
                    else if (r < 85) gen_tempo = $urandom_range(0, 23);
                    else gen_tempo = $urandom();
                end
                step_ms = gen_tempo >> 2;
                if (step_ms < MIN_STEP_MS) step_ms = MIN_STEP_MS;
                r = $urandom_range(0, 99);
                if (r < 60) gen_ms = gen_ms + step_ms + $urandom_range(0, 2);
                else if (r < 80) gen_ms = gen_ms + $urandom_range(0, step_ms - 1);
                else if (r >= 95) gen_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
                else if (r >= 90) gen_ms = $urandom();
                it.now_ms            = gen_ms;
                it.tempo_interval_ms = gen_tempo;
                it.resync            = ($urandom_range(0, 99) < 5);
            end
            if (it.action != ACT_UNUSED) made++;
            sequencer_inputs.push_back(it);
        end
    endtask

    task automatic load_patterns(input t_pattern words [PATTERN_CNT]);
        for (int i = 0; i < PATTERN_CNT; i++) begin
            @(negedge i_clk);
            i_cfg_we         = 1'b1;
            i_cfg_idx        = CFG_IDX_W'(i);
            i_cfg_data       = words[i];
            pattern_model[i] = words[i];
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Wait until every item is sent and every step has come back, then settle
    task automatic wait_for_idle();
        while (sequencer_inputs.size() != 0 || in_ch.valid || expected_steps.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Drive input items; hold each until accepted
    always @(negedge i_clk) begin
        seq_input_t next_in;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end else if (sequencer_inputs.size() != 0 &&
                         !(sequencer_inputs[0].drain_first && expected_steps.size() != 0)) begin
                next_in = sequencer_inputs.pop_front();
                in_ch.action            <= next_in.action;
                in_ch.now_ms            <= next_in.now_ms;
                in_ch.tempo_interval_ms <= next_in.tempo_interval_ms;
                in_ch.resync            <= next_in.resync;
                in_ch.rand_output       <= next_in.rand_output;
                in_ch.rand_bit_a        <= next_in.rand_bit_a;
                in_ch.rand_bit_b        <= next_in.rand_bit_b;
                in_ch.valid             <= 1'b1;
                send_gap = pick_idle(send_quiet);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
            hold_cycles = pick_idle(recv_quiet);
        end
    end

    // Check results, predict accepted items, watch for a hang
    always @(posedge i_clk) begin
        seq_input_t   seen;
        step_result_t want;
        step_result_t step;
        bit           fired;
        in_taken = 1'b0;
        fired    = 1'b0;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                fired = 1'b1;
                if (expected_steps.size() == 0) begin
                    $error("result with no step due: trigger_mask %h step_bit_used %0d %s %0b",
                           res_ch.trigger_mask, res_ch.step_bit_used, "stutter_on",
                           res_ch.stutter_on);
                    mismatches++;
                end else begin
                    want = expected_steps.pop_front();
                    results_checked++;
                    if (want.stutter_on) stutter_results++;
                    if (res_ch.trigger_mask !== want.trigger_mask) begin
                        $error("trigger_mask: expected %h, got %h",
                               want.trigger_mask, res_ch.trigger_mask);
                        mismatches++;
                    end
                    if (res_ch.step_bit_used !== want.step_bit_used) begin
                        $error("step_bit_used: expected %0d, got %0d",
                               want.step_bit_used, res_ch.step_bit_used);
                        mismatches++;
                    end
                    if (res_ch.stutter_on !== want.stutter_on) begin
                        $error("stutter_on: expected %0b, got %0b",
                               want.stutter_on, res_ch.stutter_on);
                        mismatches++;
                    end
                end
            end

            if (in_ch.valid && in_ch.ready) begin
                fired    = 1'b1;
                in_taken = 1'b1;
                seen.action            = in_ch.action;
                seen.now_ms            = in_ch.now_ms;
                seen.tempo_interval_ms = in_ch.tempo_interval_ms;
                seen.resync            = in_ch.resync;
                seen.rand_output       = in_ch.rand_output;
                seen.rand_bit_a        = in_ch.rand_bit_a;
                seen.rand_bit_b        = in_ch.rand_bit_b;
                seen.drain_first       = 1'b0;
                case (seen.action)
                    ACT_TICK:  ticks++;
                    ACT_PRESS: presses++;
                    ACT_CLEAR: clears++;
                    default:   ignored++;
                endcase
                if (advance_sequencer(seen, step)) begin
                    ticks_due++;
                    expected_steps.push_back(step);
                end
            end

            if (fired) stuck_cycles = 0;
            else stuck_cycles++;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no item moved for %0d cycles, %0d steps outstanding",
                         STALL_LIMIT, expected_steps.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_pattern words [PATTERN_CNT];
        i_rst_n                 = 1'b0;
        i_cfg_we                = 1'b0;
        i_cfg_idx               = '0;
        i_cfg_data              = '0;
        in_ch.valid             = 1'b0;
        in_ch.action            = ACT_TICK;
        in_ch.now_ms            = '0;
        in_ch.tempo_interval_ms = '0;
        in_ch.resync            = 1'b0;
        in_ch.rand_output       = '0;
        in_ch.rand_bit_a        = '0;
        in_ch.rand_bit_b        = '0;
        res_ch.ready            = 1'b0;
        foreach (pattern_model[i]) pattern_model[i] = '0;
        clear_sequencer();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: scheduling corners, wrap of time, loop lengths, clear
        words = '{16'hFFFF, 16'h0000, 16'hA5C3, 16'h8001};
        load_patterns(words);
        queue_item(ACT_TICK,   32'd0,          32'd0,          1'b0, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_TICK,   32'd0,          32'd0,          1'b0, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_TICK,   32'd4,          32'd0,          1'b0, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_TICK,   32'd5,          32'd19,         1'b0, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_TICK,   32'd100,        32'd20,         1'b0, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_TICK,   32'd105,        32'hFFFF_FFFF,  1'b1, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_TICK,   32'd106,        32'd0,          1'b1, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_PRESS,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 2'd3, 4'd15, 4'd15);
        queue_item(ACT_TICK,   32'hFFFF_FFF0,  32'd24,         1'b0, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_TICK,   32'hFFFF_FFFF,  32'd64,         1'b0, 2'd3, 4'd15, 4'd0);
        queue_item(ACT_TICK,   32'd10,         32'd64,         1'b0, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_TICK,   32'd15,         32'd64,         1'b0, 2'd2, 4'd0,  4'd0);
        queue_item(ACT_TICK,   32'd31,         32'd64,         1'b0, 2'd2, 4'd7,  4'd7);
        queue_item(ACT_PRESS,  32'd0,          32'd0,          1'b0, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_PRESS,  32'd0,          32'd0,          1'b0, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_TICK,   32'd47,         32'd64,         1'b0, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_TICK,   32'd63,         32'd64,         1'b0, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_TICK,   32'd79,         32'd64,         1'b0, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_TICK,   32'd95,         32'd64,         1'b0, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_PRESS,  32'd0,          32'd0,          1'b0, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_TICK,   32'd111,        32'd64,         1'b0, 2'd1, 4'd3,  4'd12);
        queue_item(ACT_TICK,   32'd127,        32'd64,         1'b0, 2'd0, 4'd0,  4'd1);
        queue_item(ACT_CLEAR,  32'd0,          32'd0,          1'b0, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_UNUSED, 32'd0,          32'd0,          1'b1, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_TICK,   32'd200,        32'd400,        1'b0, 2'd0, 4'd0,  4'd0);
        queue_item(ACT_TICK,   32'd300,        32'd400,        1'b1, 2'd0, 4'd0,  4'd0);
        wait_for_idle();

        // Random phases, each under its own set of patterns
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                1: words = '{default: 16'hFFFF};
                2: words = '{default: 16'h0000};
                3: words = '{16'hAAAA, 16'h5555, 16'h0001, 16'h8000};
                default: foreach (words[i]) words[i] = t_pattern'($urandom());
            endcase
            load_patterns(words);
            queue_random_phase(PHASE_ITEMS);
            wait_for_idle();
        end

        $display("Covered %0d ticks (%0d due), %0d presses, %0d clears, %0d ignored items",
                 ticks, ticks_due, presses, clears, ignored);
        $display("Checked %0d steps, %0d in stutter loops, %0d loop wraps, %0d mismatches",
                 results_checked, stutter_results, loop_wraps, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
